/* rtl/hmsw_pkg.sv */
// ----------------------------------------------------------------------------
// hmsw_pkg
// Types, limits and time-step helpers for the hours:minutes:seconds stopwatch.
// ----------------------------------------------------------------------------
package hmsw_pkg;

    localparam int ITEM_W   = 11;
    localparam int RESULT_W = 22;
    localparam int TPS_W    = 8;
    localparam int BTN_W    = 6;

    localparam logic [5:0]       SEC_LIMIT  = 6'd60;
    localparam logic [5:0]       MIN_LIMIT  = 6'd60;
    localparam logic [6:0]       HOUR_LIMIT = 7'd100;
    localparam logic [5:0]       TOP_SECMIN = 6'd59;
    localparam logic [TPS_W-1:0] TPS_RESET  = 8'd15;

    localparam int BTN_HOUR_DEC = 0;
    localparam int BTN_HOUR_INC = 1;
    localparam int BTN_MIN_DEC  = 2;
    localparam int BTN_MIN_INC  = 3;
    localparam int BTN_SEC_DEC  = 4;
    localparam int BTN_SEC_INC  = 5;

    typedef struct packed {
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } time_t;

    typedef struct packed {
        logic [BTN_W-1:0] adjust_buttons;
        logic             count_down_mode;
        logic             resume_request;
        logic             pause_request;
        logic             clear_time;
        logic             tick;
    } item_t;

    typedef struct packed {
        logic       paused_flag;
        logic       down_led;
        logic       buzzer;
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } result_t;

    function automatic time_t hour_up(input time_t t);
        time_t r;
        r = t;
        r.hours = t.hours + 7'd1;
        if (r.hours >= HOUR_LIMIT)
        begin
            r = '0;
        end
        return r;
    endfunction

    function automatic time_t min_up(input time_t t);
        time_t r;
        r = t;
        r.minutes = t.minutes + 6'd1;
        if (r.minutes >= MIN_LIMIT)
        begin
            r.minutes = '0;
            r = hour_up(r);
        end
        return r;
    endfunction

    function automatic time_t sec_up(input time_t t);
        time_t r;
        r = t;
        r.seconds = t.seconds + 6'd1;
        if (r.seconds >= SEC_LIMIT)
        begin
            r.seconds = '0;
            r = min_up(r);
        end
        return r;
    endfunction

endpackage

/* rtl/hmsw_prescaler.sv */
// ----------------------------------------------------------------------------
// hmsw_prescaler
// Tick prescaler: counts time-base ticks and flags each completed second.
// ----------------------------------------------------------------------------
module hmsw_prescaler
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      count_en,
    input  logic [hmsw_pkg::TPS_W-1:0] tps,
    output logic                      sec_pulse
);

    logic [hmsw_pkg::TPS_W-1:0] tick_count_reg;
    logic [hmsw_pkg::TPS_W-1:0] tick_count_next;
    logic [hmsw_pkg::TPS_W:0]   tick_inc;
    logic                       wrap;

    assign tick_inc  = {1'b0, tick_count_reg} + {{hmsw_pkg::TPS_W{1'b0}}, 1'b1};
    assign wrap      = tick_inc >= {1'b0, tps};
    assign sec_pulse = count_en && wrap;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (advance && count_en)
        begin
            tick_count_next = wrap ? '0 : tick_inc[hmsw_pkg::TPS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

/* rtl/hmsw_time_calc.sv */
// ----------------------------------------------------------------------------
// hmsw_time_calc
// Next time and buzzer value: one counted second, then button adjustments.
// ----------------------------------------------------------------------------
module hmsw_time_calc
(
    input  hmsw_pkg::time_t                time_in,
    input  logic                           buzzer_in,
    input  logic                           sec_pulse,
    input  logic                           down_mode,
    input  logic                           adjust_en,
    input  logic [hmsw_pkg::BTN_W-1:0]     rise,
    output hmsw_pkg::time_t                time_out,
    output logic                           buzzer_out
);

    hmsw_pkg::time_t t;
    logic            buz;

    always_comb
    begin
        t   = time_in;
        buz = buzzer_in;
        if (sec_pulse)
        begin
            if (down_mode)
            begin
                if (t.seconds != '0)
                begin
                    t.seconds = t.seconds - 6'd1;
                end
                else if (t.minutes != '0)
                begin
                    t.minutes = t.minutes - 6'd1;
                    t.seconds = hmsw_pkg::TOP_SECMIN;
                end
                else if (t.hours != '0)
                begin
                    t.hours   = t.hours - 7'd1;
                    t.minutes = hmsw_pkg::TOP_SECMIN;
                    t.seconds = hmsw_pkg::TOP_SECMIN;
                end
                else
                begin
                    buz = 1'b1;
                end
            end
            else
            begin
                buz = 1'b0;
                t   = hmsw_pkg::sec_up(t);
            end
        end
        if (adjust_en)
        begin
            if (rise[hmsw_pkg::BTN_HOUR_DEC] && t.hours != '0)
            begin
                t.hours = t.hours - 7'd1;
            end
            if (rise[hmsw_pkg::BTN_HOUR_INC])
            begin
                t = hmsw_pkg::hour_up(t);
            end
            if (rise[hmsw_pkg::BTN_MIN_DEC] && t.minutes != '0)
            begin
                t.minutes = t.minutes - 6'd1;
            end
            if (rise[hmsw_pkg::BTN_MIN_INC])
            begin
                t = hmsw_pkg::min_up(t);
            end
            if (rise[hmsw_pkg::BTN_SEC_DEC] && t.seconds != '0)
            begin
                t.seconds = t.seconds - 6'd1;
            end
            if (rise[hmsw_pkg::BTN_SEC_INC])
            begin
                t = hmsw_pkg::sec_up(t);
            end
        end
        time_out   = t;
        buzzer_out = buz;
    end

endmodule

/* rtl/hms_up_down_stopwatch_core.sv */
// A transferred sample is held in the input register, updated combinationally, and its result
// is registered for m_tdata. Throughput: one sample per clock while m_tready does not stall.
// A stalled result holds the input register; s_tready drops only when both registers
// are full and m_tready is low.
// Reset (rst_n low, asynchronous): time 00:00:00, running, buzzer off, no button held,
// prescaler at zero, ticks_per_second at 15, both registers empty.
// ----------------------------------------------------------------------------
// hms_up_down_stopwatch_core
// Up/down hours:minutes:seconds stopwatch with prescaled tick and pause adjust.
// ----------------------------------------------------------------------------
module hms_up_down_stopwatch_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hmsw_pkg::TPS_W-1:0] cfg_data,   // ticks_per_second
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // tick, clear_time, pause_request, resume_request, count_down_mode, adjust_buttons[5:0]
    input  logic [15:0]                s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // seconds[5:0], minutes[5:0], hours[6:0], buzzer, down_led, paused_flag
    output logic [23:0]                m_tdata
);

    logic                           in_valid_reg;
    hmsw_pkg::item_t                in_data_reg;
    logic                           out_valid_reg;
    hmsw_pkg::result_t              out_data_reg;
    hmsw_pkg::result_t              out_data_next;
    logic [hmsw_pkg::TPS_W-1:0]     tps_reg;
    hmsw_pkg::time_t                time_reg;
    hmsw_pkg::time_t                time_next;
    hmsw_pkg::time_t                time_cleared;
    logic                           paused_reg;
    logic                           paused_next;
    logic                           buzzer_reg;
    logic                           buzzer_next;
    logic [hmsw_pkg::BTN_W-1:0]     held_reg;
    logic [hmsw_pkg::BTN_W-1:0]     rise;
    logic                           advance;
    logic                           count_en;
    logic                           sec_pulse;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_data_reg};

    // clear, then pause, then resume
    assign time_cleared = in_data_reg.clear_time ? '0 : time_reg;
    assign paused_next  = !in_data_reg.resume_request
                          && (in_data_reg.pause_request || paused_reg);
    assign count_en     = in_data_reg.tick && !paused_next;
    assign rise         = in_data_reg.adjust_buttons & ~held_reg;

    hmsw_prescaler u_prescaler
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .count_en  (count_en),
        .tps       (tps_reg),
        .sec_pulse (sec_pulse)
    );

    hmsw_time_calc u_time_calc
    (
        .time_in    (time_cleared),
        .buzzer_in  (buzzer_reg),
        .sec_pulse  (sec_pulse),
        .down_mode  (in_data_reg.count_down_mode),
        .adjust_en  (paused_next),
        .rise       (rise),
        .time_out   (time_next),
        .buzzer_out (buzzer_next)
    );

    always_comb
    begin
        out_data_next.seconds     = time_next.seconds;
        out_data_next.minutes     = time_next.minutes;
        out_data_next.hours       = time_next.hours;
        out_data_next.buzzer      = buzzer_next;
        out_data_next.down_led    = in_data_reg.count_down_mode;
        out_data_next.paused_flag = paused_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tps_reg       <= hmsw_pkg::TPS_RESET;
            time_reg      <= '0;
            paused_reg    <= 1'b0;
            buzzer_reg    <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                time_reg      <= time_next;
                paused_reg    <= paused_next;
                buzzer_reg    <= buzzer_next;
                if (paused_next)
                begin
                    held_reg <= in_data_reg.adjust_buttons;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= hmsw_pkg::item_t'(s_tdata[hmsw_pkg::ITEM_W-1:0]);
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg.seconds < hmsw_pkg::SEC_LIMIT && time_reg.minutes < hmsw_pkg::MIN_LIMIT
        && time_reg.hours < hmsw_pkg::HOUR_LIMIT)
        else $error("time count out of range");

    a_buzzer_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(buzzer_reg) |-> $past(advance && in_data_reg.count_down_mode))
        else $error("buzzer raised without a count-down update");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(paused_reg) && $stable(time_reg) && $stable(held_reg))
        else $error("stopwatch state changed without an update");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while the pipeline can move");
`endif

endmodule
